// ===== hw/rtl/gne_pkg.sv =====
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types, constants and helpers for the grid neighborhood enumerator.
// ----------------------------------------------------------------------------
package gne_pkg;

  localparam int COORD_BITS = 8;
  localparam int SIZE_W     = COORD_BITS + 1;
  localparam int IDX_W      = 16;
  localparam int ST_W       = 2;
  localparam int RAD_W      = 2;
  localparam int CNT_W      = 3;  // window span up to 2*3+1 cells
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SIZE_W;
  localparam int DIV_STEPS  = IDX_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(1 << COORD_BITS);

  // result status codes
  localparam logic [ST_W-1:0] ST_VALID   = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_OUTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_INNER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP       = 3'd5;

  // effective (already clamped) configuration
  typedef struct packed {
    logic [SIZE_W-1:0] size_outer;
    logic [SIZE_W-1:0] size_inner;  // 1 in 1-D
    logic [RAD_W-1:0]  radius;
    logic              wrap;
    logic              skip;
  } gne_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load_center;
    logic div_step;
    logic setup;
    logic scan_step;
    logic emit_final;
    logic emit_error;
  } gne_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;
    logic div_done;
    logic scan_last;
    logic out_free;
  } gne_sts_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

endpackage

// ===== hw/rtl/gne_ctrl.sv =====
// ----------------------------------------------------------------------------
// gne_ctrl
// Sequencer: accept, divide, window setup, scan, final word; an error word for a center outside the grid.
// ----------------------------------------------------------------------------
module gne_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gne_pkg::gne_sts_t sts,
  output gne_pkg::gne_cmd_t cmd
);
  import gne_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERR   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_center = 1'b1;
          state_nxt = sts.in_range ? S_DIV : S_ERR;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit_error = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.out_free) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== hw/rtl/gne_datapath.sv =====
// ----------------------------------------------------------------------------
// gne_datapath
// Restoring divider, window counters, index build, pending and output words.
// ----------------------------------------------------------------------------
module gne_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gne_pkg::gne_cfg_t          cfg,
  input  logic [gne_pkg::IDX_W-1:0]  in_center_index,
  input  gne_pkg::gne_cmd_t          cmd,
  output gne_pkg::gne_sts_t          sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gne_pkg::IDX_W-1:0]  out_neighbor_index,
  output logic [gne_pkg::ST_W-1:0]   out_status,
  output logic                       out_last_of_run
);
  import gne_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] start;
    logic [CNT_W-1:0]      span_m1;
  } dim_win_t;

  function automatic dim_win_t dim_setup(input logic [COORD_BITS-1:0] c,
                                         input logic [SIZE_W-1:0] sz,
                                         input logic [RAD_W-1:0] r,
                                         input logic wrap);
    dim_win_t           w;
    logic signed [SIZE_W:0] v;
    logic [SIZE_W-1:0]  room;
    logic [RAD_W-1:0]   lo_m;
    logic [RAD_W-1:0]   hi;
    logic [SIZE_W-1:0]  full;
    full = SIZE_W'({r, 1'b0}) + SIZE_W'(1);
    if (wrap) begin
      v = $signed({2'b00, c}) - $signed({{(SIZE_W-1){1'b0}}, r});
      for (int k = 0; k < 3; k++) begin
        if (v < 0) v = v + $signed({1'b0, sz});
      end
      w.start   = v[COORD_BITS-1:0];
      w.span_m1 = (sz < full) ? CNT_W'(sz - SIZE_W'(1)) : CNT_W'({r, 1'b0});
    end else begin
      lo_m = ({1'b0, c} < SIZE_W'(r)) ? c[RAD_W-1:0] : r;
      room = sz - SIZE_W'(1) - {1'b0, c};
      hi   = (room < SIZE_W'(r)) ? room[RAD_W-1:0] : r;
      w.start   = c - COORD_BITS'(lo_m);
      w.span_m1 = CNT_W'(lo_m) + CNT_W'(hi);
    end
    return w;
  endfunction

  function automatic logic [COORD_BITS-1:0] coord_inc(input logic [COORD_BITS-1:0] x,
                                                      input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] n;
    n = {1'b0, x} + SIZE_W'(1);
    return (n == sz) ? '0 : n[COORD_BITS-1:0];
  endfunction

  // range check
  logic [IDX_W:0] total;
  assign total = (IDX_W+1)'(cfg.size_outer) * (IDX_W+1)'(cfg.size_inner);

  // divider
  logic [IDX_W-1:0]     center_r;
  logic [IDX_W-1:0]     dvd_r, dvd_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [SIZE_W:0]      rem_sh;
  logic                 ge;

  assign rem_sh  = {rem_r, dvd_r[IDX_W-1]};
  assign ge      = (rem_sh >= {1'b0, cfg.size_inner});
  assign rem_nxt = ge ? SIZE_W'(rem_sh - {1'b0, cfg.size_inner}) : rem_sh[SIZE_W-1:0];
  assign dvd_nxt = {dvd_r[IDX_W-2:0], ge};

  // window walk
  dim_win_t w0, w1;
  logic [COORD_BITS-1:0] x0_r, x1_r, start1_r;
  logic [CNT_W-1:0]      k0_r, k1_r, span1_r;

  assign w0 = dim_setup(dvd_r[COORD_BITS-1:0], cfg.size_outer, cfg.radius, cfg.wrap);
  assign w1 = dim_setup(rem_r[COORD_BITS-1:0], cfg.size_inner, cfg.radius, cfg.wrap);

  logic [IDX_W-1:0] cell_idx;
  logic             kept;
  assign cell_idx = IDX_W'(x0_r) * IDX_W'(cfg.size_inner) + IDX_W'(x1_r);
  assign kept     = !(cfg.skip && (cell_idx == center_r));

  // words
  logic             pend_v_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [ST_W-1:0]  out_st_r;
  logic             out_last_r;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  assign sts.in_range  = ({1'b0, in_center_index} < total);
  assign sts.div_done  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.scan_last = (k0_r == '0) && (k1_r == '0);
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load_center) begin
      center_r  <= in_center_index;
      dvd_r     <= in_center_index;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r     <= dvd_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end

    if (cmd.setup) begin
      x0_r     <= w0.start;
      x1_r     <= w1.start;
      k0_r     <= w0.span_m1;
      k1_r     <= w1.span_m1;
      start1_r <= w1.start;
      span1_r  <= w1.span_m1;
    end else if (cmd.scan_step) begin
      if (k1_r != '0) begin
        x1_r <= coord_inc(x1_r, cfg.size_inner);
        k1_r <= k1_r - CNT_W'(1);
      end else if (k0_r != '0) begin
        x0_r <= coord_inc(x0_r, cfg.size_outer);
        k0_r <= k0_r - CNT_W'(1);
        x1_r <= start1_r;
        k1_r <= span1_r;
      end
    end
  end

  // one word of lookahead so the last kept cell gets last_of_run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan_step && kept) begin
        pend_v_r   <= 1'b1;
        pend_idx_r <= cell_idx;
      end else if (cmd.emit_final) begin
        pend_v_r   <= 1'b0;
      end

      if (cmd.scan_step && kept && pend_v_r) begin
        out_valid_r <= 1'b1;
        out_idx_r   <= pend_idx_r;
        out_st_r    <= ST_VALID;
        out_last_r  <= 1'b0;
      end else if (cmd.emit_final) begin
        out_valid_r <= 1'b1;
        out_idx_r   <= pend_v_r ? pend_idx_r : '0;
        out_st_r    <= pend_v_r ? ST_VALID : ST_EMPTY;
        out_last_r  <= 1'b1;
      end else if (cmd.emit_error) begin
        out_valid_r <= 1'b1;
        out_idx_r   <= '0;
        out_st_r    <= ST_OUTSIDE;
        out_last_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_index = out_idx_r;
  assign out_status         = out_st_r;
  assign out_last_of_run    = out_last_r;

endmodule

// ===== hw/rtl/grid_neighborhood_enumerator.sv =====
// ----------------------------------------------------------------------------
// grid_neighborhood_enumerator
// Splits a flat row-major center index into coordinates and walks the square
// window around it, one neighbor word per cycle while out_stall is low, inner dimension fastest.
// ----------------------------------------------------------------------------
//
//  channel  ports                                       direction  handshake
//  -------  ------------------------------------------  ---------  -----------
//  in       in_center_index                             input      valid/stall
//  out      out_neighbor_index, out_status, out_last..  output     valid/stall
//  cfg      cfg_we, cfg_index, cfg_wdata                input      write only
//
//  Sequence: a center passes through accept, 16 divide steps, setup, one step
//  per window cell (1..49) and a final word; the divider is bit-serial and
//  the walk visits one window cell per step.
//  A center outside the grid skips the divide and gives one status word.
//  Reset (rst_n low, synchronous) returns to idle and loads the register
//  defaults: 2-D, 16 x 16, radius 1, wrap on, skip off.
//  out_stall freezes the walk; the input is taken only while idle.
//
module grid_neighborhood_enumerator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gne_pkg::IDX_W-1:0]     in_center_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gne_pkg::IDX_W-1:0]     out_neighbor_index,
  output logic [gne_pkg::ST_W-1:0]      out_status,
  output logic                          out_last_of_run,
  input  logic                          cfg_we,
  input  logic [gne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gne_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gne_pkg::*;

  // raw register file, as written
  logic [1:0]        num_dims_r;
  logic [SIZE_W-1:0] size_outer_r;
  logic [SIZE_W-1:0] size_inner_r;
  logic [RAD_W-1:0]  radius_r;
  logic              wrap_r;
  logic              skip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r   <= 2'd2;
      size_outer_r <= SIZE_W'(16);
      size_inner_r <= SIZE_W'(16);
      radius_r     <= RAD_W'(1);
      wrap_r       <= 1'b1;
      skip_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_DIMS:   num_dims_r   <= cfg_wdata[1:0];
        REG_SIZE_OUTER: size_outer_r <= cfg_wdata;
        REG_SIZE_INNER: size_inner_r <= cfg_wdata;
        REG_RADIUS:     radius_r     <= cfg_wdata[RAD_W-1:0];
        REG_WRAP:       wrap_r       <= cfg_wdata[0];
        REG_SKIP:       skip_r       <= cfg_wdata[0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // effective config: num_dims 0 acts as 1, 3 as 2; sizes clamped to 1..256;
  // 1-D forces the inner size to 1 so the flat index is the outer coordinate
  gne_cfg_t cfg;
  assign cfg.size_outer = clamp_size(size_outer_r);
  assign cfg.size_inner = num_dims_r[1] ? clamp_size(size_inner_r) : SIZE_W'(1);
  assign cfg.radius     = radius_r;
  assign cfg.wrap       = wrap_r;
  assign cfg.skip       = skip_r;

  gne_cmd_t cmd;
  gne_sts_t sts;

  gne_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gne_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_center_index    (in_center_index),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_neighbor_index (out_neighbor_index),
    .out_status         (out_status),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
